// ----- design/hrk_pkg.sv -----
// ----------------------------------------------------------------------------
// hrk_pkg
// Shared constants and key-to-character tables for the HID report decoder.
// ----------------------------------------------------------------------------
package hrk_pkg;

  // Number of key slots in a boot keyboard report
  localparam int KEY_SLOTS = 6;

  localparam int SLOT_W = 8;
  localparam int CODE_W = 7;
  localparam int CHAR_W = 8;

  // Codes at or above this limit are never reported
  localparam logic [SLOT_W-1:0] KEY_LIMIT    = 8'd104;
  // First code past the end of the translation tables
  localparam logic [CODE_W-1:0] TABLE_END    = 7'd101;
  // First code that has a table entry
  localparam logic [CODE_W-1:0] TABLE_START  = 7'd4;
  localparam logic [CHAR_W-1:0] CHAR_INVALID = 8'd255;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;

  // Modifier byte masks: left and right shift, left and right ctrl
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] CTRL_MASK  = 8'h11;

  // Control characters and cursor codes
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_ESC     = 8'd27;
  localparam logic [CHAR_W-1:0] CH_DEL     = 8'd20;
  localparam logic [CHAR_W-1:0] CH_RIGHT   = 8'd29;
  localparam logic [CHAR_W-1:0] CH_LEFT    = 8'd157;
  localparam logic [CHAR_W-1:0] CH_DOWN    = 8'd17;
  localparam logic [CHAR_W-1:0] CH_UP      = 8'd145;

  // Keypad block, identical in both tables
  function automatic logic [CHAR_W-1:0] keypad_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    case (code) inside
      7'd84:         ch = 8'd47;   // '/'
      7'd85:         ch = 8'd42;   // '*'
      7'd86:         ch = 8'd45;   // '-'
      7'd87:         ch = 8'd43;   // '+'
      7'd88:         ch = CH_LF;
      [7'd89:7'd97]: ch = {1'b0, code} - 8'd40;  // '1'..'9'
      7'd98:         ch = 8'd48;   // '0'
      default:       ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  // Unshifted table, valid for codes 4 to 100
  function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    case (code) inside
      [7'd4:7'd29]:  ch = {1'b0, code} + 8'd61;  // 'A'..'Z'
      [7'd30:7'd38]: ch = {1'b0, code} + 8'd19;  // '1'..'9'
      7'd39:         ch = 8'd48;
      7'd40:         ch = CH_CR;
      7'd41:         ch = CH_ESC;
      7'd42:         ch = CH_DEL;
      7'd43:         ch = CH_TAB;
      7'd44:         ch = 8'd32;
      7'd45:         ch = 8'd45;
      7'd46:         ch = 8'd61;
      7'd47:         ch = 8'd91;
      7'd48:         ch = 8'd93;
      7'd49:         ch = 8'd92;
      7'd50:         ch = 8'd35;
      7'd51:         ch = 8'd59;
      7'd52:         ch = 8'd39;
      7'd53:         ch = 8'd96;
      7'd54:         ch = 8'd44;
      7'd55:         ch = 8'd46;
      7'd56:         ch = 8'd47;
      7'd79:         ch = CH_RIGHT;
      7'd80:         ch = CH_LEFT;
      7'd81:         ch = CH_DOWN;
      7'd82:         ch = CH_UP;
      [7'd84:7'd98]: ch = keypad_char(code);
      7'd99:         ch = CH_DEL;
      7'd100:        ch = 8'd92;
      default:       ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  // Shifted table, valid for codes 4 to 100
  function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    case (code) inside
      [7'd4:7'd29]:  ch = {1'b0, code} + 8'd61;
      7'd30:         ch = 8'd33;
      7'd31:         ch = 8'd34;
      7'd32:         ch = 8'd42;
      7'd33:         ch = 8'd36;
      7'd34:         ch = 8'd37;
      7'd35:         ch = 8'd94;
      7'd36:         ch = 8'd38;
      7'd37:         ch = 8'd42;
      7'd38:         ch = 8'd40;
      7'd39:         ch = 8'd41;
      7'd40:         ch = CH_CR;
      7'd43:         ch = CH_TAB;
      7'd44:         ch = 8'd32;
      7'd45:         ch = 8'd95;
      7'd46:         ch = 8'd43;
      7'd47:         ch = 8'd123;
      7'd48:         ch = 8'd125;
      7'd49:         ch = 8'd124;
      7'd50:         ch = 8'd126;
      7'd51:         ch = 8'd58;
      7'd52:         ch = 8'd64;
      7'd53:         ch = 8'd42;
      7'd54:         ch = 8'd60;
      7'd55:         ch = 8'd62;
      7'd56:         ch = 8'd63;
      [7'd84:7'd98]: ch = keypad_char(code);
      7'd100:        ch = 8'd92;
      default:       ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/hrk_report_if.sv -----
// ----------------------------------------------------------------------------
// hrk_report_if
// Valid/ready channel carrying one boot keyboard report.
// ----------------------------------------------------------------------------
interface hrk_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] slot0;
  logic [7:0] slot1;
  logic [7:0] slot2;
  logic [7:0] slot3;
  logic [7:0] slot4;
  logic [7:0] slot5;

  modport source (
    output valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5,
    output ready
  );
endinterface

// ----- design/hrk_result_if.sv -----
// ----------------------------------------------------------------------------
// hrk_result_if
// Valid/ready channel carrying the decoded new key of one report.
// ----------------------------------------------------------------------------
interface hrk_result_if;
  logic       valid;
  logic       ready;
  logic       new_key_found;
  logic [6:0] key_code;
  logic [7:0] char_code;
  logic       shift_down;
  logic       ctrl_down;

  modport source (
    output valid, new_key_found, key_code, char_code, shift_down, ctrl_down,
    input  ready
  );
  modport sink (
    input  valid, new_key_found, key_code, char_code, shift_down, ctrl_down,
    output ready
  );
endinterface

// ----- design/hrk_xlat.sv -----
// ----------------------------------------------------------------------------
// hrk_xlat
// Translate a key usage code to a character through the plain or shift table.
// ----------------------------------------------------------------------------
module hrk_xlat (
  input  logic [hrk_pkg::CODE_W-1:0] key_code,
  input  logic                       shifted,
  output logic [hrk_pkg::CHAR_W-1:0] char_code
);
  import hrk_pkg::*;

  // Codes outside the tables map to the invalid marker
  always_comb begin
    if (key_code < TABLE_START || key_code >= TABLE_END) begin
      char_code = CHAR_INVALID;
    end else if (shifted) begin
      char_code = shift_char(key_code);
    end else begin
      char_code = plain_char(key_code);
    end
  end

endmodule

// ----- design/hid_report_new_key_to_char.sv -----
// ----------------------------------------------------------------------------
// hid_report_new_key_to_char
// First newly pressed key of a boot keyboard report, with its character.
// ----------------------------------------------------------------------------
// Each accepted report gives exactly one result, by way of the input
// register and then the result register. A report can be taken in
// every cycle: the input register feeds a single pass of compare and table
// logic into the result register, and both stages advance whenever the
// result register is empty or is being taken in that cycle. The slot
// compare against the previous report and the table lookup lie between
// the two registers. The previous report is updated as each report moves
// into the result register, so results follow input order.
// ----------------------------------------------------------------------------
module hid_report_new_key_to_char (
  input  logic         clk,
  input  logic         rst,
  hrk_report_if.sink   report,
  hrk_result_if.source result
);
  import hrk_pkg::*;

  // Input register
  logic              s1_valid;
  logic [7:0]        s1_mod;
  logic [SLOT_W-1:0] s1_slot [KEY_SLOTS];

  // Previous report's keys
  logic [SLOT_W-1:0] prev_keys [KEY_SLOTS];

  // Scan results
  logic [KEY_SLOTS-1:0] was_down;
  logic                 found_next;
  logic [CODE_W-1:0]    key_next;
  logic                 scan_stop;
  logic [CHAR_W-1:0]    xlat_char;
  logic                 shift_next;
  logic                 ctrl_next;

  // Result register
  logic              out_valid;
  logic              out_found;
  logic [CODE_W-1:0] out_key;
  logic [CHAR_W-1:0] out_char;
  logic              out_shift;
  logic              out_ctrl;

  logic s2_load;
  logic s1_load;

  // Advance both stages when the result register frees up
  assign s2_load      = !out_valid || result.ready;
  assign report.ready = !s1_valid || s2_load;
  assign s1_load      = report.valid && report.ready;

  // Capture the incoming report
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (report.ready) begin
      s1_valid <= report.valid;
    end
    if (s1_load) begin
      s1_mod     <= report.modifier_bits;
      s1_slot[0] <= report.slot0;
      s1_slot[1] <= report.slot1;
      s1_slot[2] <= report.slot2;
      s1_slot[3] <= report.slot3;
      s1_slot[4] <= report.slot4;
      s1_slot[5] <= report.slot5;
    end
  end

  // Mark slots whose key was held in the previous report
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      was_down[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_keys[j] == s1_slot[i]) begin
          was_down[i] = 1'b1;
        end
      end
    end
  end

  // Pick the first new key before the first empty slot
  always_comb begin
    found_next = 1'b0;
    key_next   = '0;
    scan_stop  = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (!scan_stop) begin
        if (s1_slot[i] == '0) begin
          scan_stop = 1'b1;
        end else if (!was_down[i] && s1_slot[i] < KEY_LIMIT) begin
          found_next = 1'b1;
          key_next   = s1_slot[i][CODE_W-1:0];
          scan_stop  = 1'b1;
        end
      end
    end
  end

  assign shift_next = |(s1_mod & SHIFT_MASK);
  assign ctrl_next  = |(s1_mod & CTRL_MASK);

  hrk_xlat u_xlat (
    .key_code  (key_next),
    .shifted   (shift_next),
    .char_code (xlat_char)
  );

  // Load the result and roll the previous report forward
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
    end else if (s2_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          prev_keys[i] <= s1_slot[i];
        end
      end
    end
    if (s2_load && s1_valid) begin
      out_found <= found_next;
      out_key   <= key_next;
      out_char  <= found_next ? xlat_char : CHAR_NONE;
      out_shift <= shift_next;
      out_ctrl  <= ctrl_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.new_key_found = out_found;
  assign result.key_code      = out_key;
  assign result.char_code     = out_char;
  assign result.shift_down    = out_shift;
  assign result.ctrl_down     = out_ctrl;

endmodule
